FILE: src/sbc_pkg.sv
package sbc_pkg;

  // default coordinate width, Q16.16
  localparam int COORD_WIDTH_DEF = 32;

  // fixed field widths
  localparam int R_W   = 31;   // radius, half extents, depth
  localparam int N_W   = 18;   // normal components
  localparam int TOL_W = 17;   // tolerance register
  localparam int SQ_W  = 64;   // sums of squares
  localparam int LEN_W = SQ_W / 2;
  localparam int Q_W   = 17;   // normalised magnitude, up to one
  localparam int NUM_W = 48;   // rounded dividend

  localparam logic [TOL_W-1:0] TOL_RESET = 17'd66;

  // register map, decoded on paddr[2]
  localparam logic REG_TOLERANCE = 1'b0;

endpackage

FILE: src/sphere_box_contact.sv
// Sphere against axis-aligned box contact, Q16.16. A query is taken in every
// cycle that start is high (busy never rises) and its result appears on the
// result ports for one cycle with strobe high. The pipeline holds two
// bit-per-stage square root pipelines of 32 stages each (distance, then normal
// length) and a 17-stage divider; every unit is fully pipelined, so the block
// sustains one query per cycle. The result cannot be held off: take it in the
// strobe cycle. The tolerance register sits at APB address 0 and should be
// written only while no query is in flight.
module sphere_box_contact #(
  parameter int COORD_WIDTH = sbc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] sphere_x,
  input  logic signed [COORD_WIDTH-1:0] sphere_y,
  input  logic signed [COORD_WIDTH-1:0] sphere_z,
  input  logic [sbc_pkg::R_W-1:0]       radius,
  input  logic signed [COORD_WIDTH-1:0] box_x,
  input  logic signed [COORD_WIDTH-1:0] box_y,
  input  logic signed [COORD_WIDTH-1:0] box_z,
  input  logic [sbc_pkg::R_W-1:0]       half_x,
  input  logic [sbc_pkg::R_W-1:0]       half_y,
  input  logic [sbc_pkg::R_W-1:0]       half_z,
  output logic                          strobe,
  output logic                          hit,
  output logic signed [COORD_WIDTH-1:0] point_x,
  output logic signed [COORD_WIDTH-1:0] point_y,
  output logic signed [COORD_WIDTH-1:0] point_z,
  output logic signed [sbc_pkg::N_W-1:0] normal_x,
  output logic signed [sbc_pkg::N_W-1:0] normal_y,
  output logic signed [sbc_pkg::N_W-1:0] normal_z,
  output logic [sbc_pkg::R_W-1:0]       depth
);

  localparam int CW  = COORD_WIDTH;
  localparam int VW  = CW + 1;
  localparam int XW  = ((CW > 31) ? CW : 31) + 2;
  localparam int AW  = (VW > 31) ? VW : 31;
  localparam int RW  = sbc_pkg::R_W;
  localparam int P1W = 1 + RW + 3 * CW + 6 * VW;
  localparam int P2W = 1 + 3 * CW + RW;

  // configuration register
  logic [sbc_pkg::TOL_W-1:0] tolerance;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == sbc_pkg::REG_TOLERANCE) ? 32'(tolerance) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= sbc_pkg::TOL_RESET;
    end else if (cfg_wr && paddr[2] == sbc_pkg::REG_TOLERANCE) begin
      tolerance <= pwdata[sbc_pkg::TOL_W-1:0];
    end
  end

  // the pipeline never stalls
  assign busy = 1'b0;

  // input beat register
  logic                 v0;
  logic signed [CW-1:0] s0 [3];
  logic signed [CW-1:0] b0 [3];
  logic [RW-1:0]        h0 [3];
  logic [RW-1:0]        r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s0[0] <= sphere_x;
      s0[1] <= sphere_y;
      s0[2] <= sphere_z;
      b0[0] <= box_x;
      b0[1] <= box_y;
      b0[2] <= box_z;
      h0[0] <= half_x;
      h0[1] <= half_y;
      h0[2] <= half_z;
      r0    <= radius;
    end
  end

  // offset of sphere centre from box centre
  logic                 v1;
  logic signed [XW-1:0] d1 [3];
  logic signed [CW-1:0] s1 [3];
  logic signed [CW-1:0] b1 [3];
  logic [RW-1:0]        h1 [3];
  logic [RW-1:0]        r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d1[i] <= XW'(s0[i]) - XW'(b0[i]);
      s1[i] <= s0[i];
      b1[i] <= b0[i];
      h1[i] <= h0[i];
    end
    r1 <= r0;
  end

  // clamp into the box: closest point and residual
  logic signed [XW-1:0] hx [3];
  logic signed [XW-1:0] e_x [3];
  logic signed [XW-1:0] c_x [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hx[i] = XW'($signed({1'b0, h1[i]}));
      if (d1[i] > hx[i]) begin
        e_x[i] = d1[i] - hx[i];
        c_x[i] = XW'(b1[i]) + hx[i];
      end else if (d1[i] < -hx[i]) begin
        e_x[i] = d1[i] + hx[i];
        c_x[i] = XW'(b1[i]) - hx[i];
      end else begin
        e_x[i] = '0;
        c_x[i] = XW'(s1[i]);
      end
    end
  end

  logic                 v2;
  logic signed [VW-1:0] e2 [3];
  logic signed [VW-1:0] d2 [3];
  logic signed [CW-1:0] c2 [3];
  logic [RW-1:0]        r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e2[i] <= VW'(e_x[i]);
      d2[i] <= VW'(d1[i]);
      c2[i] <= CW'(c_x[i]);
    end
    r2 <= r1;
  end

  // per-axis reject against the radius
  logic [AW-1:0] ae [3];
  logic          far2;

  always_comb begin
    far2 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ae[i] = e2[i][VW-1] ? AW'(-e2[i]) : AW'(e2[i]);
      if (ae[i] > AW'(r2)) far2 = 1'b1;
    end
  end

  logic                 v3;
  logic [RW-1:0]        a3 [3];
  logic signed [VW-1:0] e3 [3];
  logic signed [VW-1:0] d3 [3];
  logic signed [CW-1:0] c3 [3];
  logic [RW-1:0]        r3;
  logic                 miss3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a3[i] <= ae[i][RW-1:0];
      e3[i] <= e2[i];
      d3[i] <= d2[i];
      c3[i] <= c2[i];
    end
    r3    <= r2;
    miss3 <= far2;
  end

  // squares
  logic                 v4;
  logic [2*RW-1:0]      sq4 [3];
  logic [2*RW-1:0]      rr4;
  logic signed [VW-1:0] e4 [3];
  logic signed [VW-1:0] d4 [3];
  logic signed [CW-1:0] c4 [3];
  logic [RW-1:0]        r4;
  logic                 miss4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq4[i] <= (2*RW)'(a3[i]) * (2*RW)'(a3[i]);
      e4[i]  <= e3[i];
      d4[i]  <= d3[i];
      c4[i]  <= c3[i];
    end
    rr4   <= (2*RW)'(r3) * (2*RW)'(r3);
    r4    <= r3;
    miss4 <= miss3;
  end

  // squared distance
  logic                     v5;
  logic [sbc_pkg::SQ_W-1:0] sum5;
  logic [2*RW-1:0]          rr5;
  logic signed [VW-1:0]     e5 [3];
  logic signed [VW-1:0]     d5 [3];
  logic signed [CW-1:0]     c5 [3];
  logic [RW-1:0]            r5;
  logic                     miss5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    sum5 <= sbc_pkg::SQ_W'(sq4[0]) + sbc_pkg::SQ_W'(sq4[1]) + sbc_pkg::SQ_W'(sq4[2]);
    for (int i = 0; i < 3; i++) begin
      e5[i] <= e4[i];
      d5[i] <= d4[i];
      c5[i] <= c4[i];
    end
    rr5   <= rr4;
    r5    <= r4;
    miss5 <= miss4;
  end

  // distance by square root; the sphere test rides alongside
  logic [P1W-1:0] p1_in, p1_out;
  logic           miss_in;

  assign miss_in = miss5 || (sum5 > sbc_pkg::SQ_W'(rr5));
  assign p1_in   = {miss_in, r5, c5[0], c5[1], c5[2],
                    d5[0], d5[1], d5[2], e5[0], e5[1], e5[2]};

  logic                      v6;
  logic [sbc_pkg::LEN_W-1:0] dist6;

  sbc_isqrt #(
    .IW (sbc_pkg::SQ_W),
    .PW (P1W)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_x      (sum5),
    .in_pay    (p1_in),
    .out_valid (v6),
    .out_root  (dist6),
    .out_pay   (p1_out)
  );

  logic                 miss6;
  logic [RW-1:0]        r6;
  logic signed [CW-1:0] c6 [3];
  logic signed [VW-1:0] d6 [3];
  logic signed [VW-1:0] e6 [3];

  assign {miss6, r6, c6[0], c6[1], c6[2], d6[0], d6[1], d6[2], e6[0], e6[1], e6[2]} = p1_out;

  // degenerate contact picks centre-to-centre direction and full radius
  logic degen6;
  assign degen6 = (dist6 < sbc_pkg::LEN_W'(tolerance));

  logic                 v7;
  logic signed [VW-1:0] vec7 [3];
  logic [P2W-1:0]       p2_7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) vec7[i] <= degen6 ? d6[i] : e6[i];
    p2_7 <= {miss6, c6[0], c6[1], c6[2], degen6 ? r6 : (r6 - dist6[RW-1:0])};
  end

  logic                          vn;
  logic signed [sbc_pkg::N_W-1:0] nx, ny, nz;
  logic [P2W-1:0]                p2_n;

  sbc_unit #(
    .VW (VW),
    .PW (P2W)
  ) u_unit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .in_vx     (vec7[0]),
    .in_vy     (vec7[1]),
    .in_vz     (vec7[2]),
    .in_pay    (p2_7),
    .out_valid (vn),
    .out_nx    (nx),
    .out_ny    (ny),
    .out_nz    (nz),
    .out_pay   (p2_n)
  );

  logic                 miss_n;
  logic signed [CW-1:0] c_n [3];
  logic [RW-1:0]        depth_n;

  assign {miss_n, c_n[0], c_n[1], c_n[2], depth_n} = p2_n;

  // result beat, cleared on a miss
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= vn;
    end
  end

  always_ff @(posedge clk) begin
    hit      <= !miss_n;
    point_x  <= miss_n ? '0 : c_n[0];
    point_y  <= miss_n ? '0 : c_n[1];
    point_z  <= miss_n ? '0 : c_n[2];
    normal_x <= miss_n ? '0 : nx;
    normal_y <= miss_n ? '0 : ny;
    normal_z <= miss_n ? '0 : nz;
    depth    <= miss_n ? '0 : depth_n;
  end

  // checks
  logic [sbc_pkg::N_W+1:0] n_l1;
  assign n_l1 = (sbc_pkg::N_W+2)'(normal_x[sbc_pkg::N_W-1] ? -normal_x : normal_x)
              + (sbc_pkg::N_W+2)'(normal_y[sbc_pkg::N_W-1] ? -normal_y : normal_y)
              + (sbc_pkg::N_W+2)'(normal_z[sbc_pkg::N_W-1] ? -normal_z : normal_z);

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && !hit |-> point_x == 0 && point_y == 0 && point_z == 0 &&
                       normal_x == 0 && normal_y == 0 && normal_z == 0 && depth == 0)
    else $error("miss beat carries non-zero fields");

  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> normal_x >= -18'sd65536 && normal_x <= 18'sd65536 &&
               normal_y >= -18'sd65536 && normal_y <= 18'sd65536 &&
               normal_z >= -18'sd65536 && normal_z <= 18'sd65536)
    else $error("normal component beyond one");

  a_normal_unit: assert property (@(posedge clk) disable iff (rst)
    strobe && hit && (normal_x != 0 || normal_y != 0 || normal_z != 0)
      |-> n_l1 >= 20'd65534)
    else $error("normal shorter than unit length");

endmodule

FILE: src/sbc_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module sbc_isqrt #(
  parameter int IW = 64,
  parameter int PW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [IW-1:0]   in_x,
  input  logic [PW-1:0]   in_pay,
  output logic            out_valid,
  output logic [IW/2-1:0] out_root,
  output logic [PW-1:0]   out_pay
);

  localparam int ST = IW / 2;

  logic [ST:0]   vld;
  logic [IW-1:0] xs  [0:ST];
  logic [IW-1:0] res [0:ST];
  logic [PW-1:0] pay [0:ST];

  assign vld[0] = in_valid;
  assign xs[0]  = in_x;
  assign res[0] = '0;
  assign pay[0] = in_pay;

  for (genvar k = 0; k < ST; k++) begin : g_stage
    localparam logic [IW-1:0] BIT = {{(IW-1){1'b0}}, 1'b1} << (2 * (ST - 1 - k));
    logic [IW-1:0] trial;
    logic          ge;

    // trial subtract of the current root plus this bit
    always_comb begin
      trial = res[k] + BIT;
      ge    = (xs[k] >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      xs[k+1]  <= ge ? (xs[k] - trial) : xs[k];
      res[k+1] <= ge ? ((res[k] >> 1) + BIT) : (res[k] >> 1);
      pay[k+1] <= pay[k];
    end
  end

  assign out_valid = vld[ST];
  assign out_root  = res[ST][ST-1:0];
  assign out_pay   = pay[ST];

endmodule

FILE: src/sbc_div.sv
// Three-lane restoring divider over a shared divisor, one quotient bit per stage.
module sbc_div #(
  parameter int NUMW = 48,
  parameter int DW   = 32,
  parameter int QW   = 17,
  parameter int PW   = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [DW-1:0]   in_den,
  input  logic [NUMW-1:0] in_n0,
  input  logic [NUMW-1:0] in_n1,
  input  logic [NUMW-1:0] in_n2,
  input  logic [PW-1:0]   in_pay,
  output logic            out_valid,
  output logic [QW-1:0]   out_q0,
  output logic [QW-1:0]   out_q1,
  output logic [QW-1:0]   out_q2,
  output logic [PW-1:0]   out_pay
);

  localparam int TW = DW + QW;

  logic [QW:0]   vld;
  logic [DW-1:0] den [0:QW];
  logic [TW-1:0] rem [0:QW][3];
  logic [QW-1:0] quo [0:QW][3];
  logic [PW-1:0] pay [0:QW];

  assign vld[0]    = in_valid;
  assign den[0]    = in_den;
  assign rem[0][0] = TW'(in_n0);
  assign rem[0][1] = TW'(in_n1);
  assign rem[0][2] = TW'(in_n2);
  assign quo[0][0] = '0;
  assign quo[0][1] = '0;
  assign quo[0][2] = '0;
  assign pay[0]    = in_pay;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [TW-1:0] trial;
    logic [2:0]    ge;

    // shifted divisor for this quotient bit
    always_comb begin
      trial = TW'(den[j]) << (QW - 1 - j);
      for (int i = 0; i < 3; i++) ge[i] = (rem[j][i] >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      den[j+1] <= den[j];
      pay[j+1] <= pay[j];
      for (int i = 0; i < 3; i++) begin
        rem[j+1][i] <= ge[i] ? (rem[j][i] - trial) : rem[j][i];
        quo[j+1][i] <= {quo[j][i][QW-2:0], ge[i]};
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_q0    = quo[QW][0];
  assign out_q1    = quo[QW][1];
  assign out_q2    = quo[QW][2];
  assign out_pay   = pay[QW];

endmodule

FILE: src/sbc_unit.sv
// Vector normaliser: scale to a common exponent, length by square root,
// then rounded division of each component.
module sbc_unit #(
  parameter int VW = 33,
  parameter int PW = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [VW-1:0]          in_vx,
  input  logic signed [VW-1:0]          in_vy,
  input  logic signed [VW-1:0]          in_vz,
  input  logic [PW-1:0]                 in_pay,
  output logic                          out_valid,
  output logic signed [sbc_pkg::N_W-1:0] out_nx,
  output logic signed [sbc_pkg::N_W-1:0] out_ny,
  output logic signed [sbc_pkg::N_W-1:0] out_nz,
  output logic [PW-1:0]                 out_pay
);

  localparam int NW  = (VW > 31) ? VW : 31;
  localparam int SL  = $clog2(NW);
  localparam int SW  = PW + 4;                 // side band: pay, signs, zero
  localparam int TW  = 31;
  localparam int IPW = SW + 3 * TW;
  localparam int QW  = sbc_pkg::Q_W;

  logic signed [VW-1:0] vin [3];
  assign vin[0] = in_vx;
  assign vin[1] = in_vy;
  assign vin[2] = in_vz;

  // magnitudes and signs
  logic          va;
  logic [VW-1:0] mag_a [3];
  logic [2:0]    sgn_a;
  logic [PW-1:0] pay_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag_a[i] <= vin[i][VW-1] ? VW'(-vin[i]) : VW'(vin[i]);
      sgn_a[i] <= vin[i][VW-1];
    end
    pay_a <= in_pay;
  end

  // largest magnitude
  logic [VW-1:0] mx01, mxa;
  always_comb begin
    mx01 = (mag_a[1] > mag_a[0]) ? mag_a[1] : mag_a[0];
    mxa  = (mag_a[2] > mx01) ? mag_a[2] : mx01;
  end

  logic [SL:0]   vn;
  logic [NW-1:0] nm   [0:SL][3];
  logic [NW-1:0] mx   [0:SL];
  logic [SW-1:0] side [0:SL];

  always_ff @(posedge clk) begin
    if (rst) begin
      vn[0] <= 1'b0;
    end else begin
      vn[0] <= va;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) nm[0][i] <= NW'(mag_a[i]);
    mx[0]   <= NW'(mxa);
    side[0] <= {pay_a, sgn_a, (mxa == '0)};
  end

  // log-step left justification of the largest magnitude
  for (genvar j = 0; j < SL; j++) begin : g_norm
    localparam int SH = 1 << (SL - 1 - j);
    logic sh;
    assign sh = (mx[j][NW-1 -: SH] == '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        vn[j+1] <= 1'b0;
      end else begin
        vn[j+1] <= vn[j];
      end
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) nm[j+1][i] <= sh ? (nm[j][i] << SH) : nm[j][i];
      mx[j+1]   <= sh ? (mx[j] << SH) : mx[j];
      side[j+1] <= side[j];
    end
  end

  // squares of the top 31 bits
  logic          vc;
  logic [TW-1:0] t_c  [3];
  logic [61:0]   sq_c [3];
  logic [SW-1:0] side_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vn[SL];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      t_c[i]  <= nm[SL][i][NW-1 -: TW];
      sq_c[i] <= 62'(nm[SL][i][NW-1 -: TW]) * 62'(nm[SL][i][NW-1 -: TW]);
    end
    side_c <= side[SL];
  end

  // sum of squares
  logic                      vd;
  logic [sbc_pkg::SQ_W-1:0]  sum_d;
  logic [IPW-1:0]            ipay_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    sum_d  <= sbc_pkg::SQ_W'(sq_c[0]) + sbc_pkg::SQ_W'(sq_c[1]) + sbc_pkg::SQ_W'(sq_c[2]);
    ipay_d <= {side_c, t_c[0], t_c[1], t_c[2]};
  end

  logic                       vl;
  logic [sbc_pkg::LEN_W-1:0]  len_l;
  logic [IPW-1:0]             ipay_l;

  sbc_isqrt #(
    .IW (sbc_pkg::SQ_W),
    .PW (IPW)
  ) u_len (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vd),
    .in_x      (sum_d),
    .in_pay    (ipay_d),
    .out_valid (vl),
    .out_root  (len_l),
    .out_pay   (ipay_l)
  );

  logic [TW-1:0] t_l [3];
  logic [SW-1:0] side_l;
  assign {side_l, t_l[0], t_l[1], t_l[2]} = ipay_l;

  // rounded dividends
  logic                       ve;
  logic [sbc_pkg::NUM_W-1:0]  num_e [3];
  logic [sbc_pkg::LEN_W-1:0]  len_e;
  logic [SW-1:0]              side_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else begin
      ve <= vl;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++)
      num_e[i] <= sbc_pkg::NUM_W'({t_l[i], 16'h0000}) + sbc_pkg::NUM_W'(len_l >> 1);
    len_e  <= len_l;
    side_e <= side_l;
  end

  logic          vq;
  logic [QW-1:0] q0, q1, q2;
  logic [SW-1:0] side_q;

  sbc_div #(
    .NUMW (sbc_pkg::NUM_W),
    .DW   (sbc_pkg::LEN_W),
    .QW   (QW),
    .PW   (SW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ve),
    .in_den    (len_e),
    .in_n0     (num_e[0]),
    .in_n1     (num_e[1]),
    .in_n2     (num_e[2]),
    .in_pay    (side_e),
    .out_valid (vq),
    .out_q0    (q0),
    .out_q1    (q1),
    .out_q2    (q2),
    .out_pay   (side_q)
  );

  // sign and zero vector
  logic [PW-1:0]               pay_q;
  logic [2:0]                  sgn_q;
  logic                        zero_q;
  logic [QW-1:0]               qv [3];
  logic signed [sbc_pkg::N_W-1:0] nres [3];

  assign {pay_q, sgn_q, zero_q} = side_q;
  assign qv[0] = q0;
  assign qv[1] = q1;
  assign qv[2] = q2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (zero_q) nres[i] = '0;
      else if (sgn_q[i]) nres[i] = -$signed(sbc_pkg::N_W'(qv[i]));
      else nres[i] = $signed(sbc_pkg::N_W'(qv[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vq;
    end
  end

  always_ff @(posedge clk) begin
    out_nx  <= nres[0];
    out_ny  <= nres[1];
    out_nz  <= nres[2];
    out_pay <= pay_q;
  end

endmodule
